[rtl/core/cmavg_pkg.sv]
// ----------------------------------------------------------------------------
// cmavg_pkg
// Shared sizes, types and helpers of the centered moving average block.
// ----------------------------------------------------------------------------
package cmavg_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int MAX_HALF_WIDTH = 16;
    localparam int HIST_DEPTH     = 2 * MAX_HALF_WIDTH + 1;
    localparam int CNT_W          = $clog2(HIST_DEPTH + 1);
    localparam int SUM_W          = SAMPLE_BITS + CNT_W;
    localparam int NUM_W          = SUM_W + 1;
    localparam int DIV_W          = CNT_W + 1;
    localparam int CYC_W          = $clog2(NUM_W);
    localparam int CFG_W          = 6;
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(2);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic        [CNT_W-1:0]       t_cnt;
    typedef logic signed [SUM_W-1:0]       t_sum;

    typedef struct packed {
        logic shift;
        logic rotate;
    } t_cell_ctl;

    typedef struct packed {
        logic start;
        t_sum sum;
        t_cnt den;
    } t_div_req;

    typedef struct packed {
        logic    done;
        t_sample value;
    } t_div_rsp;

    function automatic t_cnt half_of(input logic [CFG_W-1:0] wp);
        logic [CFG_W-1:0] h;
        h = wp >> 1;
        if (h > CFG_W'(MAX_HALF_WIDTH)) begin
            return t_cnt'(MAX_HALF_WIDTH);
        end
        return t_cnt'(h);
    endfunction

endpackage

[rtl/core/cmavg_in_if.sv]
// ----------------------------------------------------------------------------
// cmavg_in_if
// Sample channel: valid/ready handshake with sample and end-of-set flag.
// ----------------------------------------------------------------------------
interface cmavg_in_if;
    logic                valid;
    logic                ready;
    cmavg_pkg::t_sample  sample;
    logic                is_final;

    modport source (output valid, output sample, output is_final, input ready);
    modport sink   (input valid, input sample, input is_final, output ready);
endinterface

[rtl/core/cmavg_out_if.sv]
// ----------------------------------------------------------------------------
// cmavg_out_if
// Result channel: valid/ready handshake with smoothed value and end flag.
// ----------------------------------------------------------------------------
interface cmavg_out_if;
    logic                valid;
    logic                ready;
    cmavg_pkg::t_sample  smoothed;
    logic                end_of_set;

    modport source (output valid, output smoothed, output end_of_set, input ready);
    modport sink   (input valid, input smoothed, input end_of_set, output ready);
endinterface

[rtl/core/centered_moving_average.sv]
// ----------------------------------------------------------------------------
// centered_moving_average
// Centered moving average over finite data sets with shrinking edge windows.
// ----------------------------------------------------------------------------
// One sample is taken per transfer and the block works on one sample at a
// time. A sample that produces no result leaves the block idle. Each result
// takes one full turn of the 33-cell history ring past the accumulator tap,
// then a bit-serial rounding divider that works through the dividend one bit
// at a time. A flagged last sample produces up to half+1 results in a row,
// oldest first, the last one with end_of_set set. The result register lets
// the next sample in while a result still waits for its transfer.
// window_points may be written at any time the block is idle; the
// configuration channel is always ready.
// ----------------------------------------------------------------------------
module centered_moving_average (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    cmavg_in_if.sink                       i_in,
    cmavg_out_if.source                    o_out,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [cmavg_pkg::CFG_W-1:0]    i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ACC  = 4'b0010,
        S_DIV  = 4'b0100,
        S_PUT  = 4'b1000
    } t_state;

    localparam cmavg_pkg::t_cnt LAST_POS = cmavg_pkg::t_cnt'(cmavg_pkg::HIST_DEPTH - 1);

    t_state                          r_state, n_state;
    logic [cmavg_pkg::CFG_W-1:0]     r_wp;
    cmavg_pkg::t_cnt                 r_seen,  n_seen;
    cmavg_pkg::t_cnt                 r_n,     n_n;
    cmavg_pkg::t_cnt                 r_half,  n_half;
    cmavg_pkg::t_cnt                 r_k,     n_k;
    logic                            r_fin,   n_fin;
    cmavg_pkg::t_cnt                 r_pos,   n_pos;
    cmavg_pkg::t_sum                 r_acc,   n_acc;
    logic                            r_start, n_start;
    cmavg_pkg::t_sample              r_res,   n_res;
    logic                            r_out_valid, n_out_valid;
    cmavg_pkg::t_sample              r_out_data,  n_out_data;
    logic                            r_out_end,   n_out_end;

    logic                            w_in_xfer;
    cmavg_pkg::t_cnt                 w_half_now;
    cmavg_pkg::t_cnt                 w_ipart;
    cmavg_pkg::t_cnt                 w_rad;
    cmavg_pkg::t_cnt                 w_lo;
    cmavg_pkg::t_cnt                 w_hi;
    cmavg_pkg::t_sum                 w_add;
    cmavg_pkg::t_cell_ctl            w_ctl;
    cmavg_pkg::t_div_req             w_req;
    cmavg_pkg::t_div_rsp             w_rsp;
    cmavg_pkg::t_sample              w_tap [cmavg_pkg::HIST_DEPTH];

    // history ring, newest at cell 0; rotating walks older entries to the tap
    for (genvar g = 0; g < cmavg_pkg::HIST_DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            cmavg_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_prev  (i_in.sample),
                .i_next  (w_tap[(g + 1) % cmavg_pkg::HIST_DEPTH]),
                .o_value (w_tap[g])
            );
        end else begin : g_body
            cmavg_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_prev  (w_tap[g - 1]),
                .i_next  (w_tap[(g + 1) % cmavg_pkg::HIST_DEPTH]),
                .o_value (w_tap[g])
            );
        end
    end

    cmavg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_cfg_ready      = 1'b1;
    assign o_out.valid      = r_out_valid;
    assign o_out.smoothed   = r_out_data;
    assign o_out.end_of_set = r_out_end;

    always_comb begin
        w_in_xfer  = i_in.valid && i_in.ready;
        w_half_now = cmavg_pkg::half_of(r_wp);

        w_ipart = (r_n >= cmavg_pkg::t_cnt'(r_k + r_half)) ? r_half
                                                           : cmavg_pkg::t_cnt'(r_n - r_k);
        w_rad   = (w_ipart < r_k) ? w_ipart : r_k;
        w_lo    = cmavg_pkg::t_cnt'(r_k - w_rad);
        w_hi    = cmavg_pkg::t_cnt'(r_k + w_rad);
        w_add   = ((r_pos >= w_lo) && (r_pos <= w_hi)) ? cmavg_pkg::t_sum'(w_tap[0]) : '0;

        w_ctl.shift  = w_in_xfer;
        w_ctl.rotate = (r_state == S_ACC);

        w_req.start = r_start;
        w_req.sum   = r_acc;
        w_req.den   = cmavg_pkg::t_cnt'({w_rad, 1'b1});

        n_state     = r_state;
        n_seen      = r_seen;
        n_n         = r_n;
        n_half      = r_half;
        n_k         = r_k;
        n_fin       = r_fin;
        n_pos       = r_pos;
        n_acc       = r_acc;
        n_start     = 1'b0;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_end   = r_out_end;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_n    = r_seen;
                    n_fin  = i_in.is_final;
                    n_half = w_half_now;
                    n_pos  = '0;
                    if (i_in.is_final) begin
                        n_seen  = '0;
                        n_k     = (r_seen < w_half_now) ? r_seen : w_half_now;
                        n_state = S_ACC;
                    end else begin
                        if (r_seen != cmavg_pkg::t_cnt'(cmavg_pkg::HIST_DEPTH)) begin
                            n_seen = cmavg_pkg::t_cnt'(r_seen + 1'b1);
                        end
                        if (r_seen >= w_half_now) begin
                            n_k     = w_half_now;
                            n_state = S_ACC;
                        end
                    end
                end
            end
            S_ACC: begin
                n_acc = ((r_pos == '0) ? cmavg_pkg::t_sum'(0) : r_acc) + w_add;
                if (r_pos == LAST_POS) begin
                    n_pos   = '0;
                    n_start = 1'b1;
                    n_state = S_DIV;
                end else begin
                    n_pos = cmavg_pkg::t_cnt'(r_pos + 1'b1);
                end
            end
            S_DIV: begin
                if (w_rsp.done) begin
                    n_res   = w_rsp.value;
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_out_end   = r_fin && (r_k == '0);
                    if (r_fin && (r_k != '0)) begin
                        n_k     = cmavg_pkg::t_cnt'(r_k - 1'b1);
                        n_pos   = '0;
                        n_state = S_ACC;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= cmavg_pkg::CFG_RESET;
            r_seen      <= '0;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_seen      <= n_seen;
            r_start     <= n_start;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_wp <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_half     <= n_half;
        r_k        <= n_k;
        r_fin      <= n_fin;
        r_pos      <= n_pos;
        r_acc      <= n_acc;
        r_res      <= n_res;
        r_out_data <= n_out_data;
        r_out_end  <= n_out_end;
    end

    a_seen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= cmavg_pkg::t_cnt'(cmavg_pkg::HIST_DEPTH))
        else $error("sample count above history depth");

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.is_final) |=> (r_seen == '0))
        else $error("sample count not cleared after last sample");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == S_DIV))
        else $error("divider result outside divide phase");

    a_center_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |-> ((r_k <= r_half) && (r_pos <= LAST_POS)))
        else $error("window center or ring position out of range");

endmodule

[rtl/core/cmavg_cell.sv]
// ----------------------------------------------------------------------------
// cmavg_cell
// One history cell: takes its newer neighbor on a shift, its older-side
// neighbor on a rotate, else holds.
// ----------------------------------------------------------------------------
module cmavg_cell (
    input  logic                  i_clk,
    input  cmavg_pkg::t_cell_ctl  i_ctl,
    input  cmavg_pkg::t_sample    i_prev,
    input  cmavg_pkg::t_sample    i_next,
    output cmavg_pkg::t_sample    o_value
);

    cmavg_pkg::t_sample r_value;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_value <= i_prev;
        end else if (i_ctl.rotate) begin
            r_value <= i_next;
        end
    end

    assign o_value = r_value;

endmodule

[rtl/core/cmavg_div.sv]
// ----------------------------------------------------------------------------
// cmavg_div
// Rounded signed divide of a window sum by an odd count, one quotient bit
// per cycle (restoring), ties away from zero.
// ----------------------------------------------------------------------------
module cmavg_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cmavg_pkg::t_div_req  i_req,
    output cmavg_pkg::t_div_rsp  o_rsp
);

    typedef enum logic [3:0] {
        D_IDLE = 4'b0001,
        D_PREP = 4'b0010,
        D_RUN  = 4'b0100,
        D_FIN  = 4'b1000
    } t_dstate;

    t_dstate                            r_state, n_state;
    logic                               r_done,  n_done;
    logic                               r_neg,   n_neg;
    cmavg_pkg::t_cnt                    r_den,   n_den;
    logic [cmavg_pkg::NUM_W-1:0]        r_num,   n_num;
    logic [cmavg_pkg::DIV_W-1:0]        r_rem,   n_rem;
    logic [cmavg_pkg::CYC_W-1:0]        r_cnt,   n_cnt;
    cmavg_pkg::t_sample                 r_value, n_value;

    logic [cmavg_pkg::SUM_W-1:0]        w_abs;
    logic [cmavg_pkg::DIV_W:0]          w_trial;
    logic [cmavg_pkg::DIV_W-1:0]        w_dvs;
    logic [cmavg_pkg::DIV_W:0]          w_diff;
    logic                               w_ge;
    logic [cmavg_pkg::NUM_W-1:0]        w_qneg;

    always_comb begin
        w_abs   = i_req.sum[cmavg_pkg::SUM_W-1]
                ? (cmavg_pkg::SUM_W'(0) - cmavg_pkg::SUM_W'(i_req.sum))
                : cmavg_pkg::SUM_W'(i_req.sum);
        w_trial = {r_rem, r_num[cmavg_pkg::NUM_W-1]};
        w_dvs   = {r_den, 1'b0};
        w_ge    = (w_trial >= {1'b0, w_dvs});
        w_diff  = w_trial - {1'b0, w_dvs};
        w_qneg  = cmavg_pkg::NUM_W'(0) - r_num;

        n_state = r_state;
        n_done  = 1'b0;
        n_neg   = r_neg;
        n_den   = r_den;
        n_num   = r_num;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_value = r_value;

        unique case (r_state)
            D_IDLE: begin
                if (i_req.start) begin
                    n_neg   = i_req.sum[cmavg_pkg::SUM_W-1];
                    n_num   = cmavg_pkg::NUM_W'(w_abs);
                    n_den   = i_req.den;
                    n_state = D_PREP;
                end
            end
            D_PREP: begin
                // 2*|sum| + d over 2*d gives the rounded quotient
                n_num   = (r_num << 1) + cmavg_pkg::NUM_W'(r_den);
                n_rem   = '0;
                n_cnt   = '0;
                n_state = D_RUN;
            end
            D_RUN: begin
                n_rem = w_ge ? cmavg_pkg::DIV_W'(w_diff) : cmavg_pkg::DIV_W'(w_trial);
                n_num = {r_num[cmavg_pkg::NUM_W-2:0], w_ge};
                if (r_cnt == cmavg_pkg::CYC_W'(cmavg_pkg::NUM_W - 1)) begin
                    n_state = D_FIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            D_FIN: begin
                n_value = r_neg ? cmavg_pkg::SAMPLE_BITS'(w_qneg)
                                : cmavg_pkg::SAMPLE_BITS'(r_num);
                n_done  = 1'b1;
                n_state = D_IDLE;
            end
            default: begin
                n_state = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg   <= n_neg;
        r_den   <= n_den;
        r_num   <= n_num;
        r_rem   <= n_rem;
        r_cnt   <= n_cnt;
        r_value <= n_value;
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = r_value;

endmodule
